>>> hw/rtl/ccrm_pkg.sv
// Shared types, widths, codes and helper functions for the Coulomb contact core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ccrm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int F_W       = 34;
    localparam int MUL_W     = 64;
    localparam int DIV_W     = F_W - 1 + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int ADDR_W    = 5;
    localparam int IDX_W     = ADDR_W - 2;

    localparam logic [CFG_W-1:0] K_RESET = CFG_W'(1) << FRAC_BITS;

    localparam logic [IDX_W-1:0] REG_FRICTION  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_STIFFNESS = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_COHESION  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_TENSILE   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_ENABLE    = IDX_W'(4);

    typedef enum logic [1:0] {
        OP_TRIAL  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_REVERT = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [CFG_W-1:0] mu;
        logic [CFG_W-1:0] k;
        logic [CFG_W-1:0] c;
        logic [CFG_W-1:0] ten;
        logic             fe;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic lim_start;
        logic lim_apply;
        logic calc_slip;
        logic mul_ts;
        logic mul_mu;
        logic calc_yield;
        logic gam_start;
        logic corr;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_trial;
        logic need_lim;
        logic div_done;
        logic yield_hit;
        logic sliding;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] val;
    } clip_t;

    function automatic clip_t clip64(input logic signed [MUL_W-1:0] x);
        clip_t r;
        if (x[MUL_W-1:DATA_W-1] == '0 || x[MUL_W-1:DATA_W-1] == '1) begin
            r.sat = 1'b0;
            r.val = x[DATA_W-1:0];
        end else begin
            r.sat = 1'b1;
            r.val = x[MUL_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [MUL_W-1:0] sext64(input logic [DATA_W-1:0] x);
        return {{(MUL_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

endpackage

>>> hw/rtl/ccrm_regs.sv
// APB-style configuration registers of the contact core.
// Depends on ccrm_pkg for widths, register indexes and cfg_t.
`timescale 1ns / 1ps

module ccrm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccrm_pkg::ADDR_W-1:0]   paddr,
    input  logic [ccrm_pkg::DATA_W-1:0]   pwdata,
    output logic [ccrm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ccrm_pkg::cfg_t                cfg
);
    import ccrm_pkg::*;

    logic [CFG_W-1:0] mu_reg;
    logic [CFG_W-1:0] k_reg;
    logic [CFG_W-1:0] c_reg;
    logic [CFG_W-1:0] ten_reg;
    logic             fe_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg  <= '0;
            k_reg   <= K_RESET;
            c_reg   <= '0;
            ten_reg <= '0;
            fe_reg  <= 1'b1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FRICTION:  mu_reg  <= pwdata[CFG_W-1:0];
                REG_STIFFNESS: k_reg   <= pwdata[CFG_W-1:0];
                REG_COHESION:  c_reg   <= pwdata[CFG_W-1:0];
                REG_TENSILE:   ten_reg <= pwdata[CFG_W-1:0];
                REG_ENABLE:    fe_reg  <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FRICTION:  prdata = DATA_W'(mu_reg);
            REG_STIFFNESS: prdata = DATA_W'(k_reg);
            REG_COHESION:  prdata = DATA_W'(c_reg);
            REG_TENSILE:   prdata = DATA_W'(ten_reg);
            REG_ENABLE:    prdata = DATA_W'(fe_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.mu  = mu_reg;
    assign cfg.k   = k_reg;
    assign cfg.c   = c_reg;
    assign cfg.ten = ten_reg;
    assign cfg.fe  = fe_reg;

endmodule

>>> hw/rtl/ccrm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ccrm_pkg for DIV_W, CFG_W and DIV_CNT_W.
`timescale 1ns / 1ps

module ccrm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ccrm_pkg::DIV_W-1:0]   dividend,
    input  logic [ccrm_pkg::CFG_W-1:0]   divisor,
    output logic [ccrm_pkg::DIV_W-1:0]   quotient,
    output logic                         done
);
    import ccrm_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [CFG_W:0]       trial;
    logic [CFG_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> hw/rtl/ccrm_datapath.sv
// Datapath of the contact core: slip state, shared multiplier, yield test,
// correction, output register. Depends on ccrm_pkg and ccrm_div.
`timescale 1ns / 1ps

module ccrm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ccrm_pkg::cfg_t                      cfg,
    input  ccrm_pkg::cmd_t                      cmd,
    output ccrm_pkg::sts_t                      sts,
    input  logic [1:0]                          operation,
    input  logic signed [ccrm_pkg::DATA_W-1:0]  gap,
    input  logic signed [ccrm_pkg::DATA_W-1:0]  slip_increment,
    input  logic signed [ccrm_pkg::DATA_W-1:0]  normal_force,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [ccrm_pkg::DATA_W-1:0]  normal_force_out,
    output logic signed [ccrm_pkg::DATA_W-1:0]  tangential_force,
    output logic signed [ccrm_pkg::DATA_W-1:0]  gap_out,
    output logic                                sliding,
    output logic [ccrm_pkg::CFG_W-1:0]          tangent_shear,
    output logic signed [ccrm_pkg::DATA_W-1:0]  tangent_coupling,
    output logic                                saturated
);
    import ccrm_pkg::*;

    op_t                      op_reg;
    logic signed [DATA_W-1:0] gap_reg;
    logic signed [DATA_W-1:0] slip_reg;
    logic signed [DATA_W-1:0] tn_reg;
    logic [CFG_W-1:0]         mu_reg;
    logic [CFG_W-1:0]         k_reg;
    logic [CFG_W-1:0]         c_reg;
    logic [CFG_W-1:0]         ten_reg;
    logic signed [DATA_W-1:0] committed_reg;
    logic signed [DATA_W-1:0] trial_reg;
    logic signed [DATA_W-1:0] s_reg;
    logic signed [DATA_W-1:0] ts_reg;
    logic signed [DATA_W-1:0] mutn_reg;
    logic signed [F_W-1:0]    f_reg;
    logic                     active_reg;
    logic                     open_reg;
    logic                     hit_reg;
    logic                     neg_reg;
    logic                     sliding_reg;
    logic                     sat_reg;
    logic                     out_valid_reg;

    logic signed [DATA_W-1:0] nf_out_reg;
    logic signed [DATA_W-1:0] tf_out_reg;
    logic signed [DATA_W-1:0] gap_out_reg;
    logic                     sl_out_reg;
    logic [CFG_W-1:0]         shear_out_reg;
    logic signed [DATA_W-1:0] coup_out_reg;
    logic                     sat_out_reg;

    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [CFG_W-1:0]         div_divisor;
    logic [DIV_W-1:0]         div_quo;
    logic                     div_done;

    logic signed [DATA_W:0]   tn_ten;
    logic                     active;
    logic                     open_now;
    clip_t                    slip_clip;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [MUL_W-1:0]  mul_p;
    clip_t                    mul_clip;
    logic signed [F_W-1:0]    ts_ext;
    logic signed [F_W-1:0]    abs_ts;
    logic signed [F_W-1:0]    f_val;
    logic signed [MUL_W-1:0]  gamma_ext;
    clip_t                    corr_clip;

    assign div_start    = cmd.lim_start || cmd.gam_start;
    assign div_dividend = cmd.gam_start ? {f_reg[F_W-2:0], {FRAC_BITS{1'b0}}}
                                        : DIV_W'({c_reg, {FRAC_BITS{1'b0}}});
    assign div_divisor  = cmd.gam_start ? k_reg : mu_reg;

    ccrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_comb
    begin
        tn_ten    = $signed({tn_reg[DATA_W-1], tn_reg}) + $signed({2'b00, ten_reg});
        active    = !tn_ten[DATA_W] && (tn_ten != '0);
        open_now  = tn_ten[DATA_W];
        slip_clip = clip64(sext64(committed_reg) + sext64(slip_reg));

        mul_a     = cmd.mul_mu ? $signed({1'b0, mu_reg}) : $signed({1'b0, k_reg});
        mul_b     = cmd.mul_mu ? tn_reg : s_reg;
        mul_p     = sext64(mul_a) * sext64(mul_b);
        mul_clip  = clip64(mul_p >>> FRAC_BITS);

        ts_ext    = {{(F_W-DATA_W){ts_reg[DATA_W-1]}}, ts_reg};
        abs_ts    = ts_reg[DATA_W-1] ? -ts_ext : ts_ext;
        f_val     = abs_ts - $signed({{(F_W-DATA_W){mutn_reg[DATA_W-1]}}, mutn_reg})
                    - $signed({{(F_W-CFG_W){1'b0}}, c_reg});

        gamma_ext = $signed({{(MUL_W-DIV_W){1'b0}}, div_quo});
        corr_clip = clip64(neg_reg ? sext64(s_reg) + gamma_ext : sext64(s_reg) - gamma_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg <= '0;
            trial_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
            case (op_reg)
                OP_TRIAL:  trial_reg <= s_reg;
                OP_COMMIT: committed_reg <= trial_reg;
                OP_REVERT:
                begin
                    committed_reg <= '0;
                    trial_reg     <= '0;
                end
                default:   ;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= op_t'(operation);
            gap_reg     <= gap;
            slip_reg    <= slip_increment;
            tn_reg      <= normal_force;
            mu_reg      <= cfg.fe ? cfg.mu : '0;
            c_reg       <= cfg.fe ? cfg.c : '0;
            ten_reg     <= (cfg.fe && cfg.mu != '0) ? cfg.ten : '0;
            k_reg       <= (cfg.k == '0) ? CFG_W'(1) : cfg.k;
            sliding_reg <= 1'b0;
            sat_reg     <= 1'b0;
        end
        if (cmd.lim_apply)
        begin
            if ({{(DIV_W-CFG_W){1'b0}}, ten_reg} > div_quo)
            begin
                ten_reg <= div_quo[CFG_W-1:0];
            end
        end
        if (cmd.calc_slip)
        begin
            active_reg <= active;
            open_reg   <= open_now;
            s_reg      <= active ? slip_clip.val : '0;
            sat_reg    <= sat_reg | (active & slip_clip.sat);
        end
        if (cmd.mul_ts)
        begin
            ts_reg  <= mul_clip.val;
            sat_reg <= sat_reg | mul_clip.sat;
        end
        if (cmd.mul_mu)
        begin
            mutn_reg <= mul_clip.val;
            sat_reg  <= sat_reg | mul_clip.sat;
        end
        if (cmd.calc_yield)
        begin
            f_reg   <= f_val;
            neg_reg <= ts_reg[DATA_W-1];
            hit_reg <= !f_val[F_W-1] && (f_val != '0) && active_reg && (s_reg != '0);
        end
        if (cmd.corr)
        begin
            s_reg       <= corr_clip.val;
            sat_reg     <= sat_reg | corr_clip.sat;
            sliding_reg <= 1'b1;
        end
        if (cmd.finish)
        begin
            if (op_reg == OP_TRIAL)
            begin
                nf_out_reg    <= tn_reg;
                tf_out_reg    <= ts_reg;
                gap_out_reg   <= gap_reg;
                sl_out_reg    <= sliding_reg;
                shear_out_reg <= (open_reg || sliding_reg) ? '0 : k_reg;
                if (open_reg || !sliding_reg)
                begin
                    coup_out_reg <= '0;
                end
                else
                begin
                    coup_out_reg <= neg_reg ? -$signed({1'b0, mu_reg}) : $signed({1'b0, mu_reg});
                end
                sat_out_reg   <= sat_reg;
            end
            else
            begin
                nf_out_reg    <= '0;
                tf_out_reg    <= '0;
                gap_out_reg   <= '0;
                sl_out_reg    <= 1'b0;
                shear_out_reg <= '0;
                coup_out_reg  <= '0;
                sat_out_reg   <= 1'b0;
            end
        end
    end

    assign sts.is_trial  = (op_reg == OP_TRIAL);
    assign sts.need_lim  = (mu_reg != '0);
    assign sts.div_done  = div_done;
    assign sts.yield_hit = hit_reg;
    assign sts.sliding   = sliding_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign normal_force_out = nf_out_reg;
    assign tangential_force = tf_out_reg;
    assign gap_out          = gap_out_reg;
    assign sliding          = sl_out_reg;
    assign tangent_shear    = shear_out_reg;
    assign tangent_coupling = coup_out_reg;
    assign saturated        = sat_out_reg;

endmodule

>>> hw/rtl/ccrm_ctrl.sv
// Sequencer of the contact core: steps the datapath through one item at a time.
// Depends on ccrm_pkg for cmd_t and sts_t.
`timescale 1ns / 1ps

module ccrm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ccrm_pkg::sts_t sts,
    output ccrm_pkg::cmd_t cmd
);
    import ccrm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_LIM,
        S_SLIP,
        S_MUL_TS,
        S_MUL_MU,
        S_YIELD,
        S_CHECK,
        S_GAM,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (!sts.is_trial)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.need_lim)
                begin
                    cmd.lim_start = 1'b1;
                    state_next    = S_LIM;
                end
                else
                begin
                    state_next = S_SLIP;
                end
            end
            S_LIM:
            begin
                if (sts.div_done)
                begin
                    cmd.lim_apply = 1'b1;
                    state_next    = S_SLIP;
                end
            end
            S_SLIP:
            begin
                cmd.calc_slip = 1'b1;
                state_next    = S_MUL_TS;
            end
            S_MUL_TS:
            begin
                cmd.mul_ts = 1'b1;
                state_next = sts.sliding ? S_FINISH : S_MUL_MU;
            end
            S_MUL_MU:
            begin
                cmd.mul_mu = 1'b1;
                state_next = S_YIELD;
            end
            S_YIELD:
            begin
                cmd.calc_yield = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.yield_hit)
                begin
                    cmd.gam_start = 1'b1;
                    state_next    = S_GAM;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_GAM:
            begin
                if (sts.div_done)
                begin
                    cmd.corr   = 1'b1;
                    state_next = S_MUL_TS;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/coulomb_contact_return_map_core.sv
// Top level of the Coulomb contact return-mapping core.
// Depends on ccrm_pkg, ccrm_regs, ccrm_ctrl, ccrm_datapath and ccrm_div.
//
// Items enter on the in_valid/in_ready channel: an operation code (trial,
// commit, revert, no-op), gap, slip increment and normal force in Q16.16.
// Each item gives exactly one result on out_valid/out_ready; commit, revert
// and no-op give an all-zero result; commit and revert update the slip state.
// The block takes one item at a time. Commit, revert and no-op go from the
// prep step straight to the finish step. A trial item steps through the
// slip update, the two products and the yield test; with friction enabled
// and a nonzero coefficient it first divides for the tension cutoff, and
// when the yield test trips it divides again for the slip correction. Both
// quotients come from one shared bit-serial divider of 49 quotient bits.
// The result sits in an output register; in_ready rises again as soon as the
// result is registered, so the next item is taken while the receiver stalls.
// A finished item waits for the output register to drain before it is shown.
// Reset clears the slip state, empties the output register and loads the
// register defaults (stiffness 1.0, friction enabled, all else zero).
// Write configuration only while the block is idle.
`timescale 1ns / 1ps

module coulomb_contact_return_map_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ccrm_pkg::ADDR_W-1:0]         paddr,
    input  logic [ccrm_pkg::DATA_W-1:0]         pwdata,
    output logic [ccrm_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic signed [ccrm_pkg::DATA_W-1:0]  gap,
    input  logic signed [ccrm_pkg::DATA_W-1:0]  slip_increment,
    input  logic signed [ccrm_pkg::DATA_W-1:0]  normal_force,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ccrm_pkg::DATA_W-1:0]  normal_force_out,
    output logic signed [ccrm_pkg::DATA_W-1:0]  tangential_force,
    output logic signed [ccrm_pkg::DATA_W-1:0]  gap_out,
    output logic                                sliding,
    output logic [ccrm_pkg::CFG_W-1:0]          tangent_shear,
    output logic signed [ccrm_pkg::DATA_W-1:0]  tangent_coupling,
    output logic                                saturated
);
    import ccrm_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    ccrm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ccrm_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (operation),
        .gap              (gap),
        .slip_increment   (slip_increment),
        .normal_force     (normal_force),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .normal_force_out (normal_force_out),
        .tangential_force (tangential_force),
        .gap_out          (gap_out),
        .sliding          (sliding),
        .tangent_shear    (tangent_shear),
        .tangent_coupling (tangent_coupling),
        .saturated        (saturated)
    );

endmodule
